@@ rtl/rtue_pkg.sv @@
package rtue_pkg;

	localparam int unsigned LINE_BYTES = 256;
	localparam int unsigned MAX_COLS   = 256;

	localparam int unsigned CP_W    = 21;
	localparam int unsigned CNT_W   = 9;
	localparam int unsigned NBYTE_W = 3;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic [CNT_W-1:0] BYTE_LIMIT = CNT_W'(LINE_BYTES - 5);
	localparam logic [CNT_W-1:0] SPACE_CAP  = CNT_W'((MAX_COLS < 511) ? MAX_COLS : 511);

	localparam logic [CP_W-1:0] CP_SPACE = CP_W'(32'h20);

	typedef logic [3:0][7:0] utf8_bytes_t;

	typedef struct packed {
		logic [NBYTE_W-1:0] count;
		utf8_bytes_t        bytes;
	} utf8_enc_t;

endpackage

@@ rtl/rtue_utf8_enc.sv @@
module rtue_utf8_enc (
	input  logic [rtue_pkg::CP_W-1:0] code_point,
	output rtue_pkg::utf8_enc_t       enc
);
	import rtue_pkg::*;

	always_comb begin
		enc.bytes = '0;
		if (code_point < CP_W'(32'h80)) begin
			enc.count    = NBYTE_W'(1);
			enc.bytes[0] = code_point[7:0];
		end else if (code_point < CP_W'(32'h800)) begin
			enc.count    = NBYTE_W'(2);
			enc.bytes[0] = {3'b110, code_point[10:6]};
			enc.bytes[1] = {2'b10, code_point[5:0]};
		end else if (code_point < CP_W'(32'h10000)) begin
			enc.count    = NBYTE_W'(3);
			enc.bytes[0] = {4'b1110, code_point[15:12]};
			enc.bytes[1] = {2'b10, code_point[11:6]};
			enc.bytes[2] = {2'b10, code_point[5:0]};
		end else begin
			enc.count    = NBYTE_W'(4);
			enc.bytes[0] = {5'b11110, code_point[20:18]};
			enc.bytes[1] = {2'b10, code_point[17:12]};
			enc.bytes[2] = {2'b10, code_point[11:6]};
			enc.bytes[3] = {2'b10, code_point[5:0]};
		end
	end

endmodule

@@ rtl/row_trim_utf8_encoder_core.sv @@
// Row trimmer and UTF-8 encoder for a terminal row.
// Input stream: one cell per request; s_tdata carries the code point, s_tuser
// flags the right half of a wide glyph, s_tlast marks the last cell of the row.
// Blank cells (zero, space, wide tail) only count pending spaces; a later
// visible cell produces one result with the space run and its 1 to 4 bytes
// (none at the byte limit). Output stream: one result per visible cell until
// the row stops and one per last cell, with m_tlast set on the row's closing
// result and line_length reporting the total. A request passes the input
// register, then the result register. Throughput: one cell per cycle unless
// the receiver stalls; trim and encode is a single logic pass between the registers.
// Reset (arst_n low) empties both registers and clears the pending space
// count, the byte count and the stop flag. State also returns to zero after
// every last cell.
// When the receiver stalls, the result register holds its request and the
// input register stops advancing; s_tready drops once both are full, so no
// request is lost or duplicated.
module row_trim_utf8_encoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rtue_pkg::IN_DATA_W-1:0]    s_tdata,  // code_point[20:0], zero pad
	input  logic                              s_tuser,  // wide_tail
	input  logic                              s_tlast,  // row_end
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rtue_pkg::OUT_DATA_W-1:0]   m_tdata,  // space_run[8:0], byte_count[11:9],
	                                                    // byte0..byte3[43:12], line_length[52:44]
	output logic                              m_tlast   // line_done
);
	import rtue_pkg::*;

	// input register
	logic            valid_s1;
	logic [CP_W-1:0] cp_s1;
	logic            tail_s1;
	logic            last_s1;

	// row state
	logic [CNT_W-1:0] pending_q;
	logic [CNT_W-1:0] written_q;
	logic             stopped_q;

	// result register
	logic                  out_valid_q;
	logic [CNT_W-1:0]      run_q;
	logic [NBYTE_W-1:0]    count_q;
	utf8_bytes_t           bytes_q;
	logic                  done_q;
	logic [CNT_W-1:0]      length_q;

	utf8_enc_t        enc;
	logic             out_free;
	logic             advance;
	logic             blank;
	logic             has_result;
	logic [CNT_W-1:0] room;
	logic [CNT_W-1:0] run;
	logic [CNT_W-1:0] after_run;
	logic             emit_char;
	logic [CNT_W-1:0] after_char;
	logic [CNT_W-1:0] res_run;
	logic [NBYTE_W-1:0] res_count;
	utf8_bytes_t      res_bytes;

	rtue_utf8_enc u_enc (
		.code_point(cp_s1),
		.enc       (enc)
	);

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_comb begin
		blank      = tail_s1 || (cp_s1 == '0) || (cp_s1 == CP_SPACE);
		has_result = last_s1 || (!blank && !stopped_q);
		room       = BYTE_LIMIT - written_q;
		run        = (pending_q < room) ? pending_q : room;
		after_run  = written_q + run;
		emit_char  = after_run < BYTE_LIMIT;
		after_char = emit_char ? after_run + CNT_W'(enc.count) : after_run;
		res_run    = '0;
		res_count  = '0;
		res_bytes  = '0;
		if (!blank && !stopped_q) begin
			res_run = run;
			if (emit_char) begin
				res_count = enc.count;
				res_bytes = enc.bytes;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cp_s1   <= s_tdata[CP_W-1:0];
			tail_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			written_q <= '0;
			stopped_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pending_q <= '0;
				written_q <= '0;
				stopped_q <= 1'b0;
			end else if (blank) begin
				if (!stopped_q && pending_q < SPACE_CAP) begin
					pending_q <= pending_q + CNT_W'(1);
				end
			end else if (!stopped_q) begin
				pending_q <= '0;
				written_q <= after_char;
				stopped_q <= after_char >= BYTE_LIMIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			run_q    <= res_run;
			count_q  <= res_count;
			bytes_q  <= res_bytes;
			done_q   <= last_s1;
			// blank or stopped cells leave the count as it was
			length_q <= (!blank && !stopped_q) ? after_char : written_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = done_q;
	assign m_tdata  = {3'b000, length_q, bytes_q[3], bytes_q[2], bytes_q[1], bytes_q[0],
		count_q, run_q};

endmodule
